// ===== rtl/core/tte_pkg.sv =====
// ----------------------------------------------------------------------------
// tte_pkg
// Types, character codes and sizes shared by the text terminal cursor engine.
// ----------------------------------------------------------------------------
package tte_pkg;

	localparam int MAX_COLUMNS_DEF = 256;
	localparam int MAX_ROWS_DEF    = 128;

	localparam int OPQ_DEPTH  = 2;
	localparam int OUTQ_DEPTH = 4;

	localparam logic [7:0] ESC_BYTE    = 8'hFF;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_ONE      = 8'h31;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_NEWLINE  = 8'h0A;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_DIGIT_0  = 8'h30;
	localparam logic [7:0] CH_DIGIT_9  = 8'h39;
	localparam logic [7:0] CH_LOWER_A  = 8'h61;
	localparam logic [7:0] CH_LOWER_F  = 8'h66;
	localparam logic [7:0] CH_UPPER_A  = 8'h41;
	localparam logic [7:0] CH_UPPER_F  = 8'h46;
	localparam logic [7:0] HEX_LETTER_OFFSET = 8'd10;

	localparam logic [3:0] ESC_IDLE      = 4'd0;
	localparam logic [3:0] ESC_GOT_START = 4'd1;
	localparam logic [3:0] ESC_GOT_BRACKET = 4'd2;
	localparam logic [3:0] ESC_FIRST_DIGIT = 4'd3;
	localparam logic [3:0] ESC_LAST_DIGIT  = 4'd8;

	localparam logic [23:0] FOREGROUND_RESET = 24'hFFFFFF;
	localparam logic [23:0] BACKGROUND_RESET = 24'h000000;
	localparam logic [7:0]  TEXT_ROWS_RESET  = 8'd25;
	localparam logic [7:0]  WRAP_LIMIT_RESET = 8'd78;
	localparam logic [7:0]  LINE_COUNT_MAX   = 8'd255;

	typedef enum logic [1:0] {
		REG_FOREGROUND = 2'd0,
		REG_BACKGROUND = 2'd1,
		REG_TEXT_ROWS  = 2'd2,
		REG_WRAP_LIMIT = 2'd3
	} reg_index_t;

	typedef enum logic [2:0] {
		OP_CLEAR,
		OP_ESC,
		OP_GLYPH,
		OP_SPACE,
		OP_TAB,
		OP_NEWLINE
	} op_kind_t;

	typedef enum logic [1:0] {
		EV_GLYPH  = 2'd0,
		EV_SCROLL = 2'd1,
		EV_CLEAR  = 2'd2
	} event_kind_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [7:0]  ch;
		logic [23:0] rgb;
		logic        start;
	} op_t;

	typedef struct packed {
		event_kind_t kind;
		logic [7:0]  glyph;
		logic [7:0]  column;
		logic [6:0]  row;
		logic [23:0] rgb;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [23:0] foreground;
		logic [23:0] background;
		logic [7:0]  text_rows;
		logic [7:0]  wrap_limit;
	} cfg_t;

endpackage

// ===== rtl/core/text_terminal_cursor_engine.sv =====
// ----------------------------------------------------------------------------
// text_terminal_cursor_engine
// Turns a terminal byte stream into glyph, scroll and clear-screen words.
// ----------------------------------------------------------------------------
// One byte or clear command is taken every cycle unless full is set. The
// front stage decodes color escapes and classifies the byte in the cycle it
// is pushed; the cursor stage takes it from a two-word operation queue once
// the output queue has room and writes its result words there. Each
// operation gives zero, one or two result words into a four-word output
// queue; the cursor stage takes an operation only while two slots are free,
// so full rises when the consumer holds off pop or when two-word operations
// arrive faster than the words are popped.
module text_terminal_cursor_engine #(
	parameter int MAX_COLUMNS = tte_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = tte_pkg::MAX_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	output logic        full,
	input  logic        command,
	input  logic [7:0]  char_byte,
	input  logic        string_start,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  event_kind,
	output logic [7:0]  glyph_code,
	output logic [7:0]  cell_column,
	output logic [6:0]  cell_row,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        last
);
	import tte_pkg::*;

	cfg_t       cfg_q;
	reg_index_t reg_idx;
	logic       cfg_wr, accept;
	op_t        front_op, head_op;
	logic       opq_empty, op_take;
	result_t    res;

	assign pready  = 1'b1;
	assign reg_idx = reg_index_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.foreground <= FOREGROUND_RESET;
			cfg_q.background <= BACKGROUND_RESET;
			cfg_q.text_rows  <= TEXT_ROWS_RESET;
			cfg_q.wrap_limit <= WRAP_LIMIT_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_FOREGROUND: cfg_q.foreground <= pwdata[23:0];
				REG_BACKGROUND: cfg_q.background <= pwdata[23:0];
				REG_TEXT_ROWS:  cfg_q.text_rows  <= pwdata[7:0];
				REG_WRAP_LIMIT: cfg_q.wrap_limit <= pwdata[7:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FOREGROUND: prdata = {8'd0, cfg_q.foreground};
			REG_BACKGROUND: prdata = {8'd0, cfg_q.background};
			REG_TEXT_ROWS:  prdata = {24'd0, cfg_q.text_rows};
			REG_WRAP_LIMIT: prdata = {24'd0, cfg_q.wrap_limit};
		endcase
	end

	assign accept = push && !full;

	tte_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.command      (command),
		.char_byte    (char_byte),
		.string_start (string_start),
		.foreground   (cfg_q.foreground),
		.op           (front_op)
	);

	tte_opq u_opq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  (front_op),
		.full   (full),
		.pop    (op_take),
		.rdata  (head_op),
		.empty  (opq_empty)
	);

	tte_back #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (!opq_empty),
		.op        (head_op),
		.op_take   (op_take),
		.cfg       (cfg_q),
		.res       (res),
		.res_empty (empty),
		.res_pop   (pop)
	);

	assign event_kind  = res.kind;
	assign glyph_code  = res.glyph;
	assign cell_column = res.column;
	assign cell_row    = res.row;
	assign red         = res.rgb[23:16];
	assign green       = res.rgb[15:8];
	assign blue        = res.rgb[7:0];
	assign last        = res.last;

endmodule

// ===== rtl/core/tte_front.sv =====
// ----------------------------------------------------------------------------
// tte_front
// Takes terminal bytes, tracks color escape sequences and classifies each
// byte into an operation for the cursor stage.
// ----------------------------------------------------------------------------
module tte_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic          command,
	input  logic [7:0]    char_byte,
	input  logic          string_start,
	input  logic [23:0]   foreground,
	output tte_pkg::op_t  op
);
	import tte_pkg::*;

	logic [3:0]  esc_pos_q, esc_pos_nxt, esc_eff;
	logic [23:0] shift_q, shift_nxt, digit_shift;
	logic        all_f_q, all_f_nxt, digit_all_f;
	logic [23:0] color_q, color_nxt, color_eff;
	logic        in_esc;

	function automatic logic [3:0] nibble(input logic [7:0] b);
		logic [7:0] d;
		begin
			if (b >= CH_DIGIT_0 && b <= CH_DIGIT_9) begin
				d = b - CH_DIGIT_0;
			end else if (b >= CH_LOWER_A && b <= CH_LOWER_F) begin
				d = b - CH_LOWER_A + HEX_LETTER_OFFSET;
			end else if (b >= CH_UPPER_A && b <= CH_UPPER_F) begin
				d = b - CH_UPPER_A + HEX_LETTER_OFFSET;
			end else begin
				d = b;
			end
			nibble = d[3:0];
		end
	endfunction

	always_comb begin
		esc_eff     = string_start ? ESC_IDLE : esc_pos_q;
		color_eff   = string_start ? foreground : color_q;
		in_esc      = (esc_eff != ESC_IDLE) || (char_byte == ESC_BYTE);
		digit_shift = {shift_q[19:0], nibble(char_byte)};
		digit_all_f = all_f_q && (char_byte == CH_LOWER_F);

		esc_pos_nxt = esc_eff;
		shift_nxt   = shift_q;
		all_f_nxt   = all_f_q;
		color_nxt   = color_eff;

		op.ch    = char_byte;
		op.rgb   = color_eff;
		op.start = string_start;
		op.kind  = OP_GLYPH;

		if (command) begin
			op.kind     = OP_CLEAR;
			esc_pos_nxt = esc_pos_q;
			color_nxt   = color_q;
		end else if (in_esc) begin
			op.kind = OP_ESC;
			unique case (esc_eff)
				ESC_IDLE: begin
					esc_pos_nxt = ESC_GOT_START;
				end
				ESC_GOT_START: begin
					esc_pos_nxt = (char_byte == CH_LBRACKET) ? ESC_GOT_BRACKET : ESC_IDLE;
				end
				ESC_GOT_BRACKET: begin
					if (char_byte == CH_ONE) begin
						esc_pos_nxt = ESC_FIRST_DIGIT;
						shift_nxt   = '0;
						all_f_nxt   = 1'b1;
					end else begin
						esc_pos_nxt = ESC_IDLE;
					end
				end
				default: begin
					shift_nxt = digit_shift;
					all_f_nxt = digit_all_f;
					if (esc_eff >= ESC_LAST_DIGIT) begin
						esc_pos_nxt = ESC_IDLE;
						color_nxt   = digit_all_f ? foreground : digit_shift;
					end else begin
						esc_pos_nxt = esc_eff + 4'd1;
					end
				end
			endcase
		end else begin
			priority if (char_byte == CH_NEWLINE) begin
				op.kind = OP_NEWLINE;
			end else if (char_byte == CH_TAB) begin
				op.kind = OP_TAB;
			end else if (char_byte == CH_SPACE) begin
				op.kind = OP_SPACE;
			end else begin
				op.kind = OP_GLYPH;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_pos_q <= ESC_IDLE;
			shift_q   <= '0;
			all_f_q   <= 1'b1;
			color_q   <= FOREGROUND_RESET;
		end else if (accept) begin
			esc_pos_q <= esc_pos_nxt;
			shift_q   <= shift_nxt;
			all_f_q   <= all_f_nxt;
			color_q   <= color_nxt;
		end
	end

endmodule

// ===== rtl/core/tte_opq.sv =====
// ----------------------------------------------------------------------------
// tte_opq
// Short queue of classified operations between the front and cursor stages.
// ----------------------------------------------------------------------------
module tte_opq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tte_pkg::op_t  wdata,
	output logic          full,
	input  logic          pop,
	output tte_pkg::op_t  rdata,
	output logic          empty
);
	import tte_pkg::*;

	localparam int PW = $clog2(OPQ_DEPTH);
	localparam int CW = $clog2(OPQ_DEPTH + 1);

	op_t            mem [OPQ_DEPTH];
	logic [PW-1:0]  wp_q, rp_q;
	logic [CW-1:0]  cnt_q;
	logic           do_push, do_pop;

	assign full    = (cnt_q == CW'(OPQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= wp_q + PW'(1);
			end
			if (do_pop) begin
				rp_q <= rp_q + PW'(1);
			end
			cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
		end
	end

endmodule

// ===== rtl/core/tte_back.sv =====
// ----------------------------------------------------------------------------
// tte_back
// Cursor stage: applies wrapping, newlines, scrolling and clears to the
// cursor and writes up to two result words per operation to the output queue.
// ----------------------------------------------------------------------------
module tte_back #(
	parameter int MAX_COLUMNS = tte_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = tte_pkg::MAX_ROWS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	input  tte_pkg::op_t      op,
	output logic              op_take,
	input  tte_pkg::cfg_t     cfg,
	output tte_pkg::result_t  res,
	output logic              res_empty,
	input  logic              res_pop
);
	import tte_pkg::*;

	localparam int CW = $clog2(MAX_COLUMNS);
	localparam int RW = $clog2(MAX_ROWS);
	localparam int QP = $clog2(OUTQ_DEPTH);
	localparam int QC = $clog2(OUTQ_DEPTH + 1);

	logic [CW-1:0] col_q, col_nxt, col_a, col_inc;
	logic [RW-1:0] row_q, row_nxt, row_a, last_row;
	logic [RW:0]   rows, wrap_step, line_step;
	logic [7:0]    lc_q, lc_nxt, lc_a, lc_b;
	logic          pnl_q, pnl_nxt, pnl_eff;
	logic          wf_q, wf_nxt, wf_eff, wf_a;
	logic          wrap, skip;
	logic          e1_valid, e2_valid;
	result_t       e1, e2, r0, r1;
	logic [1:0]    nres;

	result_t       mem [OUTQ_DEPTH];
	logic [QP-1:0] wp_q, rp_q;
	logic [QC-1:0] cnt_q;
	logic          do_pop;

	function automatic logic [RW:0] newline_step(input logic [RW-1:0] r,
			input logic [RW:0] nrows, input logic [RW-1:0] lrow);
		logic [RW:0] inc;
		begin
			inc = {1'b0, r} + (RW + 1)'(1);
			if (inc >= nrows) begin
				newline_step = {1'b1, lrow};
			end else begin
				newline_step = {1'b0, inc[RW-1:0]};
			end
		end
	endfunction

	always_comb begin
		if (cfg.text_rows == 8'd0) begin
			rows = (RW + 1)'(1);
		end else if (32'(cfg.text_rows) > MAX_ROWS) begin
			rows = (RW + 1)'(MAX_ROWS);
		end else begin
			rows = (RW + 1)'(cfg.text_rows);
		end
		last_row = RW'(rows - (RW + 1)'(1));
	end

	always_comb begin
		pnl_eff = op.start ? 1'b0 : pnl_q;
		wf_eff  = op.start ? 1'b0 : wf_q;

		wrap      = (lc_q > cfg.wrap_limit) && (op.kind != OP_NEWLINE);
		wrap_step = newline_step(row_q, rows, last_row);
		col_a     = wrap ? '0 : col_q;
		row_a     = wrap ? wrap_step[RW-1:0] : row_q;
		wf_a      = wrap ? 1'b1 : wf_eff;
		lc_a      = wrap ? 8'd0 : lc_q;
		skip      = (pnl_eff || wf_a) && (op.kind == OP_SPACE);
		line_step = newline_step(row_a, rows, last_row);
		col_inc   = (col_a == CW'(MAX_COLUMNS - 1)) ? '0 : col_a + CW'(1);
		lc_b      = (op.kind == OP_NEWLINE) ? 8'd0 : lc_a;

		col_nxt = col_q;
		row_nxt = row_q;
		lc_nxt  = lc_q;
		pnl_nxt = pnl_q;
		wf_nxt  = wf_q;

		e1       = '0;
		e2       = '0;
		e1_valid = 1'b0;
		e2_valid = 1'b0;

		unique case (op.kind)
			OP_CLEAR: begin
				col_nxt  = '0;
				row_nxt  = '0;
				e2.kind  = EV_CLEAR;
				e2.rgb   = cfg.background;
				e2_valid = 1'b1;
			end
			OP_ESC: begin
				pnl_nxt = 1'b0;
				wf_nxt  = wf_eff;
			end
			default: begin
				e1.kind  = EV_SCROLL;
				e1.row   = 7'(row_a);
				e1_valid = wrap && wrap_step[RW];
				col_nxt  = col_a;
				row_nxt  = row_a;
				lc_nxt   = lc_a;
				if (skip) begin
					wf_nxt  = 1'b0;
					pnl_nxt = 1'b0;
				end else begin
					if (op.kind == OP_NEWLINE) begin
						col_nxt  = '0;
						row_nxt  = line_step[RW-1:0];
						e2.kind  = EV_SCROLL;
						e2.row   = 7'(line_step[RW-1:0]);
						e2_valid = line_step[RW];
					end else if (op.kind != OP_TAB) begin
						col_nxt   = col_inc;
						e2.kind   = EV_GLYPH;
						e2.glyph  = op.ch;
						e2.column = 8'(col_a);
						e2.row    = 7'(row_a);
						e2.rgb    = op.rgb;
						e2_valid  = 1'b1;
					end
					wf_nxt  = 1'b0;
					pnl_nxt = (op.kind == OP_NEWLINE);
					lc_nxt  = (lc_b == LINE_COUNT_MAX) ? LINE_COUNT_MAX : lc_b + 8'd1;
				end
			end
		endcase

		r0 = e1_valid ? e1 : e2;
		r1 = e2;
		nres = 2'(e1_valid) + 2'(e2_valid);
		r0.last = (nres == 2'd1);
		r1.last = 1'b1;
	end

	assign op_take   = op_valid && (cnt_q <= QC'(OUTQ_DEPTH - 2));
	assign res_empty = (cnt_q == '0);
	assign do_pop    = res_pop && !res_empty;
	assign res       = mem[rp_q];

	always_ff @(posedge clk) begin
		if (op_take) begin
			if (nres != 2'd0) begin
				mem[wp_q] <= r0;
			end
			if (nres == 2'd2) begin
				mem[wp_q + QP'(1)] <= r1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			lc_q  <= '0;
			pnl_q <= 1'b0;
			wf_q  <= 1'b0;
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (op_take) begin
				col_q <= col_nxt;
				row_q <= row_nxt;
				lc_q  <= lc_nxt;
				pnl_q <= pnl_nxt;
				wf_q  <= wf_nxt;
				wp_q  <= wp_q + QP'(nres);
			end
			if (do_pop) begin
				rp_q <= rp_q + QP'(1);
			end
			cnt_q <= cnt_q + (op_take ? QC'(nres) : QC'(0)) - QC'(do_pop);
		end
	end

	a_outq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QC'(OUTQ_DEPTH))
		else $error("output queue overfilled");

	a_clear_home: assert property (@(posedge clk) disable iff (!arst_n)
		(op_take && op.kind == OP_CLEAR) |=> (col_q == '0 && row_q == '0))
		else $error("clear did not home the cursor");

	a_esc_clears_newline: assert property (@(posedge clk) disable iff (!arst_n)
		(op_take && op.kind == OP_ESC) |=> !pnl_q)
		else $error("escape byte left the newline flag set");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(row_q) < MAX_ROWS)
		else $error("cursor row beyond the screen");

endmodule
